@@ src/svv_pkg.sv @@
package svv_pkg;

   // one character transfer of the version string
   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
      logic       no_char;
   } item_type;

   // verdict leaving the parser
   typedef struct packed {
      logic valid;
      logic version_valid;
   } result_type;

   typedef enum logic [1:0] {
      SEC_CORE  = 2'd0,
      SEC_PRE   = 2'd1,
      SEC_BUILD = 2'd2
   } section_type;

   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   localparam logic [1:0] LEN_MAX      = 2'd2;
   localparam logic [1:0] LAST_CORE_IX = 2'd2;

endpackage

@@ src/svv_in_reg.sv @@
module svv_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  svv_pkg::item_type req_item,
   input  logic              take,
   output logic              item_valid,
   output svv_pkg::item_type item
);
   import svv_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign req_ready  = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

@@ src/svv_parser.sv @@
module svv_parser #(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  svv_pkg::item_type   item,
   output svv_pkg::result_type result
);
   import svv_pkg::*;

   localparam int WIDE = NUMBER_WIDTH + 4;

   section_type             sec_ff, sec_in, sec_c;
   logic [1:0]              idx_ff, idx_in, idx_c;
   logic [NUMBER_WIDTH-1:0] val_ff, val_in, val_c;
   logic [1:0]              len_ff, len_in, len_c;
   logic                    sz_ff, sz_in, sz_c;
   logic                    ad_ff, ad_in, ad_c;
   logic                    fail_ff, fail_in, fail_c;

   logic [7:0]      c;
   logic            is_digit, is_ident;
   logic [WIDE-1:0] scaled;
   logic            overflow;
   logic [1:0]      tk_len;
   logic            tk_sz, tk_ad;
   logic            cur_end_ok, cur_ident_ok, cur_core_ok;

   function automatic logic core_ok(input logic [1:0] len, input logic sz);
      return (len != 2'd0) && !((len == LEN_MAX) && sz);
   endfunction

   function automatic logic ident_ok(input section_type sec, input logic [1:0] len,
                                     input logic sz, input logic ad);
      return (len != 2'd0) && !((sec == SEC_PRE) && ad && (len == LEN_MAX) && sz);
   endfunction

   function automatic logic end_ok(input section_type sec, input logic [1:0] idx,
                                   input logic [1:0] len, input logic sz, input logic ad);
      if (sec == SEC_CORE) begin
         return core_ok(len, sz) && (idx == LAST_CORE_IX);
      end
      return ident_ok(sec, len, sz, ad);
   endfunction

   assign c = item.char_code;

   // 10*v + d; anything in the top nibble means it no longer fits
   assign scaled = ({4'd0, val_ff} << 3) + ({4'd0, val_ff} << 1)
                 + WIDE'(c[3:0]);
   assign overflow = |scaled[WIDE-1:NUMBER_WIDTH];

   assign tk_len = (len_ff == LEN_MAX) ? len_ff : len_ff + 2'd1;
   assign tk_sz  = (len_ff == 2'd0) ? (c == CH_ZERO) : sz_ff;

   assign cur_end_ok   = end_ok(sec_ff, idx_ff, len_ff, sz_ff, ad_ff);
   assign cur_ident_ok = ident_ok(sec_ff, len_ff, sz_ff, ad_ff);
   assign cur_core_ok  = core_ok(len_ff, sz_ff);

   always_comb begin
      is_digit = c inside {[CH_ZERO:CH_NINE]};
      is_ident = is_digit || (c inside {[CH_UPPER_A:CH_UPPER_Z]})
              || (c inside {[CH_LOWER_A:CH_LOWER_Z]}) || (c == CH_DASH);
      tk_ad    = ad_ff && is_digit;
   end

   // state after consuming this character
   always_comb begin
      sec_c  = sec_ff;
      idx_c  = idx_ff;
      val_c  = val_ff;
      len_c  = len_ff;
      sz_c   = sz_ff;
      ad_c   = ad_ff;
      fail_c = fail_ff;
      if (fire && !item.no_char && !fail_ff) begin
         case (sec_ff)
            SEC_CORE: begin
               if (is_digit) begin
                  if (overflow) begin
                     fail_c = 1'b1;
                  end else begin
                     val_c = scaled[NUMBER_WIDTH-1:0];
                  end
                  len_c = tk_len;
                  sz_c  = tk_sz;
                  ad_c  = tk_ad;
               end else if (c == CH_DOT) begin
                  if (!cur_core_ok || idx_ff >= LAST_CORE_IX) begin
                     fail_c = 1'b1;
                  end else begin
                     idx_c = idx_ff + 2'd1;
                     val_c = '0;
                     len_c = 2'd0;
                     sz_c  = 1'b0;
                     ad_c  = 1'b1;
                  end
               end else if (c == CH_DASH || c == CH_PLUS) begin
                  if (!cur_end_ok) begin
                     fail_c = 1'b1;
                  end
                  sec_c = (c == CH_DASH) ? SEC_PRE : SEC_BUILD;
                  val_c = '0;
                  len_c = 2'd0;
                  sz_c  = 1'b0;
                  ad_c  = 1'b1;
               end else begin
                  fail_c = 1'b1;
               end
            end
            SEC_PRE: begin
               if (c == CH_DOT || c == CH_PLUS) begin
                  if (!cur_ident_ok) begin
                     fail_c = 1'b1;
                  end
                  if (c == CH_PLUS) begin
                     sec_c = SEC_BUILD;
                  end
                  val_c = '0;
                  len_c = 2'd0;
                  sz_c  = 1'b0;
                  ad_c  = 1'b1;
               end else if (is_ident) begin
                  len_c = tk_len;
                  sz_c  = tk_sz;
                  ad_c  = tk_ad;
               end else begin
                  fail_c = 1'b1;
               end
            end
            default: begin
               // build section (unused code 3 behaves the same)
               if (c == CH_DOT) begin
                  if (!cur_ident_ok) begin
                     fail_c = 1'b1;
                  end
                  val_c = '0;
                  len_c = 2'd0;
                  sz_c  = 1'b0;
                  ad_c  = 1'b1;
               end else if (is_ident) begin
                  len_c = tk_len;
                  sz_c  = tk_sz;
                  ad_c  = tk_ad;
               end else begin
                  fail_c = 1'b1;
               end
            end
         endcase
      end
   end

   // verdict on the last transfer, then back to start state
   always_comb begin
      result.valid         = fire && item.is_last;
      result.version_valid = !fail_c && end_ok(sec_c, idx_c, len_c, sz_c, ad_c);
      if (fire && item.is_last) begin
         sec_in  = SEC_CORE;
         idx_in  = 2'd0;
         val_in  = '0;
         len_in  = 2'd0;
         sz_in   = 1'b0;
         ad_in   = 1'b1;
         fail_in = 1'b0;
      end else begin
         sec_in  = sec_c;
         idx_in  = idx_c;
         val_in  = val_c;
         len_in  = len_c;
         sz_in   = sz_c;
         ad_in   = ad_c;
         fail_in = fail_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff  <= SEC_CORE;
         idx_ff  <= 2'd0;
         val_ff  <= '0;
         len_ff  <= 2'd0;
         sz_ff   <= 1'b0;
         ad_ff   <= 1'b1;
         fail_ff <= 1'b0;
      end else begin
         sec_ff  <= sec_in;
         idx_ff  <= idx_in;
         val_ff  <= val_in;
         len_ff  <= len_in;
         sz_ff   <= sz_in;
         ad_ff   <= ad_in;
         fail_ff <= fail_in;
      end
   end

endmodule

@@ src/semantic_version_validator.sv @@
// Semantic version (2.0.0) string checker.
// Request channel (req_valid/req_ready): one character per transfer in
//   req_char_code; req_no_char marks a transfer without a character (only
//   useful with req_is_last, to close a string without a character);
//   req_is_last closes the string.
// Response channel (rsp_valid/rsp_ready): one transfer per string, carrying
//   rsp_version_valid, produced by the request transfer marked last.
// Pipeline: input register, parse stage (state update + verdict), output
//   register. The verdict of the closing request transfer is formed in the
//   parse stage and held in the output register, which drives rsp_valid.
// Throughput: one character per cycle unless stalled (below); the string
//   state is updated once per cycle by the parse stage, and a core number
//   is built with a multiply-by-ten accumulator NUMBER_WIDTH bits wide.
// Stalls: while a verdict waits in the output register and rsp_ready is
//   low, the parse stage holds for every transfer, not only closing ones;
//   the input register takes at most one more transfer before req_ready
//   drops.
// Reset (synchronous, active high): empties both registers and returns the
//   parser to the start of a string. After every verdict the parser also
//   returns to the start state by itself.
module semantic_version_validator #(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_is_last,
   input  logic       req_no_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_version_valid
);
   import svv_pkg::*;

   item_type   req_item, item;
   logic       item_valid;
   logic       fire;
   result_type result;

   logic out_valid_ff, out_valid_in;
   logic out_ok_ff;

   assign req_item.char_code = req_char_code;
   assign req_item.is_last   = req_is_last;
   assign req_item.no_char   = req_no_char;

   // parse stage advances when the output register has room
   assign fire = item_valid && (!out_valid_ff || rsp_ready);

   svv_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   svv_parser #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   // output register
   always_comb begin
      if (result.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         out_ok_ff <= result.version_valid;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_version_valid = out_ok_ff;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

// Checks the version string checker: strings go in one character per
// transfer, one verdict comes back per string. The expected verdicts are
// worked out by a parser model kept in this file and compared in order.
module tb_top;
   import svv_pkg::*;

   localparam int          NUM_W          = 32;
   localparam logic [63:0] NUM_MAX        = (NUM_W >= 64) ? '1 : ((64'd1 << NUM_W) - 64'd1);
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          DRAIN_CYCLES   = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_code = 8'h00;
   logic       req_is_last = 1'b0;
   logic       req_no_char = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_version_valid;

   semantic_version_validator #(
      .NUMBER_WIDTH(NUM_W)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_char_code(req_char_code),
      .req_is_last(req_is_last),
      .req_no_char(req_no_char),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_version_valid(rsp_version_valid)
   );

   always #4 clock = ~clock;

   // random stall bursts on both channels while this is set
   bit         idle_on = 1'b1;
   int         fail_count = 0;
   int         char_count = 0;      // request transfers sent so far
   logic       verdict_q[$];        // verdicts still owed by the block, oldest first
   logic [7:0] str_buf[$];          // string being assembled for the next send
   string      ident_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-";

   // ---------------------------------------------------------------------
   // Parser model: same state the block keeps for the string in flight.
   // ---------------------------------------------------------------------
   section_type sec;
   logic [1:0]  core_ix;
   logic [63:0] part_val;
   logic [1:0]  part_len;            // saturates at two, enough for the leading-zero rule
   bit          starts_zero;
   bit          all_digits;
   bit          failed;

   function automatic bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_ident_char(logic [7:0] c);
      return is_digit(c) || (c >= CH_UPPER_A && c <= CH_UPPER_Z)
         || (c >= CH_LOWER_A && c <= CH_LOWER_Z) || c == CH_DASH;
   endfunction

   task automatic clear_part();
      part_val    = '0;
      part_len    = '0;
      starts_zero = 1'b0;
      all_digits  = 1'b1;
   endtask

   task automatic reset_parser();
      sec     = SEC_CORE;
      core_ix = '0;
      failed  = 1'b0;
      clear_part();
   endtask

   task automatic take_char(logic [7:0] c);
      bit first;
      first = (part_len == 0);
      if (part_len < LEN_MAX) part_len++;
      if (first) starts_zero = (c == CH_ZERO);
      if (!is_digit(c)) all_digits = 1'b0;
   endtask

   function automatic bit core_part_ok();
      return part_len != 0 && !(part_len > 1 && starts_zero);
   endfunction

   // a numeric prerelease identifier longer than one digit may not start with zero; build may
   function automatic bit ident_ok();
      if (part_len == 0) return 1'b0;
      if (sec == SEC_PRE && all_digits && part_len > 1 && starts_zero) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit section_end_ok();
      if (sec == SEC_CORE) return core_part_ok() && core_ix == LAST_CORE_IX;
      return ident_ok();
   endfunction

   task automatic parse_char(logic [7:0] c);
      logic [63:0] d;
      case (sec)
         SEC_CORE: begin
            if (is_digit(c)) begin
               d = 64'(c - CH_ZERO);
               // value would no longer fit the number width
               if (part_val > (NUM_MAX - d) / 64'd10) failed = 1'b1;
               else part_val = part_val * 64'd10 + d;
               take_char(c);
            end else if (c == CH_DOT) begin
               if (!core_part_ok() || core_ix >= LAST_CORE_IX) begin
                  failed = 1'b1;
               end else begin
                  core_ix++;
                  clear_part();
               end
            end else if (c == CH_DASH || c == CH_PLUS) begin
               if (!section_end_ok()) failed = 1'b1;
               sec = (c == CH_DASH) ? SEC_PRE : SEC_BUILD;
               clear_part();
            end else begin
               failed = 1'b1;
            end
         end
         SEC_PRE: begin
            if (c == CH_DOT || c == CH_PLUS) begin
               if (!ident_ok()) failed = 1'b1;
               if (c == CH_PLUS) sec = SEC_BUILD;
               clear_part();
            end else if (is_ident_char(c)) begin
               take_char(c);
            end else begin
               failed = 1'b1;
            end
         end
         default: begin
            // build section; a second '+' is just a bad character here
            if (c == CH_DOT) begin
               if (!ident_ok()) failed = 1'b1;
               clear_part();
            end else if (is_ident_char(c)) begin
               take_char(c);
            end else begin
               failed = 1'b1;
            end
         end
      endcase
   endtask

   // one accepted request transfer; a closing one owes a verdict
   task automatic predict_verdict(logic [7:0] c, bit last, bit none);
      if (!none && !failed) parse_char(c);
      if (last) begin
         verdict_q.push_back(!failed && section_end_ok());
         reset_parser();
      end
   endtask

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   task automatic send_item(logic [7:0] c, bit last, bit none);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_is_last   <= last;
      req_no_char   <= none;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_verdict(c, last, none);
      char_count++;
   endtask

   // sends str_buf as one string; empty-character transfers are sprinkled in
   // and sometimes close the string instead of the last character
   task automatic send_buf();
      bit close_empty;
      int n;
      n = str_buf.size();
      close_empty = (n == 0) || ($urandom_range(0, 7) == 0);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         send_item(str_buf[i], !close_empty && i == n - 1, 1'b0);
      end
      if (close_empty) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
   endtask

   task automatic send_text(string s);
      str_buf.delete();
      add_text(s);
      send_buf();
   endtask

   function automatic logic [7:0] rand_byte();
      string punct;
      punct = "0123456789.-+Aaz";
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
      return punct[$urandom_range(0, punct.len() - 1)];
   endfunction

   // core number, biased toward the overflow boundary and leading zeros
   task automatic add_number();
      logic [63:0] val;
      int          r;
      r = $urandom_range(0, 9);
      if (r == 8) begin
         add_text($sformatf("0%0d", $urandom_range(0, 99)));
      end else begin
         case (r)
            5:       val = 64'($urandom_range(10, 999));
            6:       val = NUM_MAX - 64'd2 + 64'($urandom_range(0, 4));
            7:       val = {32'b0, $urandom()};
            9:       val = NUM_MAX * 64'd10 + 64'($urandom_range(0, 19));
            default: val = 64'($urandom_range(0, 9));
         endcase
         add_text($sformatf("%0d", val));
      end
   endtask

   task automatic add_ident();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: ;  // empty identifier
         1: add_text($sformatf("0%0d", $urandom_range(0, 99)));
         2: add_text($sformatf("%0d", $urandom_range(0, 999)));
         default: begin
            repeat ($urandom_range(1, 4))
               str_buf.push_back(ident_chars[$urandom_range(0, ident_chars.len() - 1)]);
         end
      endcase
   endtask

   task automatic add_ident_list();
      int n;
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
         if (i > 0) str_buf.push_back(CH_DOT);
         add_ident();
      end
   endtask

   // mostly well-formed versions with random content; some broken or noise
   task automatic make_version();
      int kind;
      int parts;
      int pos;
      str_buf.delete();
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         // empty string
      end else if (kind <= 2) begin
         repeat ($urandom_range(1, 6)) str_buf.push_back(rand_byte());
      end else begin
         parts = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 3;
         for (int p = 0; p < parts; p++) begin
            if (p > 0) str_buf.push_back(CH_DOT);
            add_number();
         end
         if ($urandom_range(0, 1) == 0) begin
            str_buf.push_back(CH_DASH);
            add_ident_list();
         end
         if ($urandom_range(0, 2) == 0) begin
            str_buf.push_back(CH_PLUS);
            add_ident_list();
         end
         if ($urandom_range(0, 3) == 0 && str_buf.size() > 0) begin
            pos = $urandom_range(0, str_buf.size() - 1);
            case ($urandom_range(0, 2))
               0:       str_buf[pos] = rand_byte();
               1:       str_buf.insert(pos, rand_byte());
               default: str_buf.delete(pos);
            endcase
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: ready in random bursts, checker on every transfer
   // ---------------------------------------------------------------------
   initial begin : ready_driver
      int n;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 2) == 0) rsp_ready <= 1'b0;
         else rsp_ready <= 1'b1;
         n = $urandom_range(1, 16);
         repeat (n - 1) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      logic exp_bit;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: verdict %0b with none expected", $time, rsp_version_valid);
            fail_count++;
         end else begin
            exp_bit = verdict_q.pop_front();
            if (rsp_version_valid !== exp_bit) begin
               $display("%0t: version_valid mismatch, expected %0b, actual %0b",
                        $time, exp_bit, rsp_version_valid);
               fail_count++;
            end
         end
      end
   end

   // stop a hung run: count cycles without any transfer on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_core_numbers();
      send_text("0.0.0");
      send_text("10.20.30");
      send_text("4294967295.4294967295.0");   // largest value that fits
      send_text("4294967296.0.0");            // one past the limit
      send_text("01.2.3");
      send_text("1.02.3");
   endtask

   task automatic test_core_shape();
      send_text("1.2");
      send_text("1.2.3.4");
      send_text("1..3");
      send_text("1.2.3.");
   endtask

   task automatic test_prerelease_build();
      send_text("1.0.0-alpha.1+build.9-z");
      send_text("1.0.0-01");                  // numeric prerelease with leading zero
      send_text("1.0.0-0a.0");
      send_text("1.0.0+01.007");              // build allows leading zeros
      send_text("1.0.0-");
      send_text("1.0.0-a..b");
      send_text("1.0.0+a+b");                 // extra plus in build
      send_text("1.2.3-x-y.Z--");
   endtask

   task automatic test_bad_bytes();
      send_text("1.0.0 b");
      send_text("v1.2.3");                    // fails at once, rest ignored
      str_buf.delete();
      add_text("1.0.0-a");
      str_buf.push_back(8'h80);
      send_buf();
      str_buf.delete();
      add_text("1.0.");
      str_buf.push_back(8'hFF);
      send_buf();
   endtask

   task automatic test_empty_and_gaps();
      send_item(8'h00, 1'b1, 1'b1);           // empty string
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(CH_ONE_OR_DIGIT(1), 1'b0, 1'b0);
      send_item(8'h41, 1'b0, 1'b1);           // no character, not last: ignored
      add_text("");
      send_item(CH_DOT, 1'b0, 1'b0);
      send_item(CH_ZERO, 1'b0, 1'b0);
      send_item(CH_DOT, 1'b0, 1'b0);
      send_item(CH_NINE, 1'b0, 1'b0);
      send_item(8'h2E, 1'b1, 1'b1);           // closed without a character
   endtask

   function automatic logic [7:0] CH_ONE_OR_DIGIT(int d);
      return CH_ZERO + 8'(d);
   endfunction

   task automatic test_random_versions();
      int stop_at;
      stop_at = char_count + 470;
      while (char_count < stop_at) begin
         idle_on = ($urandom_range(0, 4) != 0);
         make_version();
         send_buf();
      end
   endtask

   task automatic test_back_to_back();
      int stop_at;
      idle_on = 1'b0;
      stop_at = char_count + 150;
      while (char_count < stop_at) begin
         make_version();
         send_buf();
      end
   endtask

   initial begin
      reset_parser();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_core_numbers();
      test_core_shape();
      test_prerelease_build();
      test_bad_bytes();
      test_empty_and_gaps();
      test_random_versions();
      test_back_to_back();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && verdict_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/svv_pkg.sv
src/svv_in_reg.sv
src/svv_parser.sv
src/semantic_version_validator.sv
tb/sv/tb_top.sv
